### hdl/rwhp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies; used by every module under hdl/.
`default_nettype none

package rwhp_pkg;

    // Four-character tags as they read little-endian from the stream
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int HDR_BYTES   = 12;
    localparam int CHUNK_HDR   = 8;
    localparam int FMT_BYTES   = 16;
    localparam int POS_W       = 34;
    localparam int LEFT_W      = 33;
    localparam int OUT_TDATA_W = 216;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_EARLY_END = 3'd3;
    localparam logic [2:0] ST_FMT_SMALL = 3'd4;
    localparam logic [2:0] ST_EXT_CUT   = 3'd5;
    localparam logic [2:0] ST_MISSING   = 3'd6;
    localparam logic [2:0] ST_OVERRUN   = 3'd7;

    // One input beat
    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_beat;

    // One summary result
    typedef struct packed {
        logic [2:0]  status;
        logic        found_format;
        logic        found_samples;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [15:0] extension_length;
        logic [31:0] samples_offset;
        logic [31:0] samples_length;
    } t_result;

endpackage

`default_nettype wire

### hdl/rwhp_in_stage.sv
// Input register for the header parser: holds one accepted byte beat.
// Depends on rwhp_pkg for the beat type.
`default_nettype none

module rwhp_in_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  rwhp_pkg::t_beat   i_beat,
    input  wire               i_take,
    output logic              o_valid,
    output rwhp_pkg::t_beat   o_beat
);

    logic            r_valid;
    rwhp_pkg::t_beat r_beat;

    // Room when empty or when the held beat moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

`default_nettype wire

### hdl/rwhp_parser.sv
// Parse state and single-step logic: consumes one byte per step and
// flags a summary result. Depends on rwhp_pkg for types and constants.
`default_nettype none

module rwhp_parser (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_step,
    input  rwhp_pkg::t_beat    i_beat,
    output logic               o_res_valid,
    output rwhp_pkg::t_result  o_res
);

    localparam logic [2:0] PH_RIFF   = 3'd0;
    localparam logic [2:0] PH_CHUNK  = 3'd1;
    localparam logic [2:0] PH_FMT    = 3'd2;
    localparam logic [2:0] PH_EXTLEN = 3'd3;
    localparam logic [2:0] PH_EXT    = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam int PW = rwhp_pkg::POS_W;
    localparam int LW = rwhp_pkg::LEFT_W;

    logic [2:0]    r_phase,    n_phase;
    logic [PW-1:0] r_pos,      n_pos;
    logic [32:0]   r_list_end, n_list_end;
    logic [31:0]   r_tag,      n_tag;
    logic [31:0]   r_len,      n_len;
    logic [LW-1:0] r_left,     n_left;
    logic [63:0]   r_field,    n_field;
    logic [63:0]   r_fmt0,     n_fmt0;
    logic [63:0]   r_fmt1,     n_fmt1;
    logic [63:0]   r_place,    n_place;
    logic [15:0]   r_ext,      n_ext;
    logic [1:0]    r_found,    n_found;

    logic [PW-1:0] pos1;
    logic          skip_req;
    logic          next_req;
    logic [LW-1:0] consumed;
    logic [LW-1:0] len_inc;
    logic [LW-1:0] padded;
    logic [LW-1:0] rem;
    logic          st_valid;
    logic [2:0]    st_code;
    logic          res_valid;
    logic [2:0]    res_code;
    logic [7:0]    b;

    // One parse step
    always_comb begin
        b          = i_beat.file_byte;
        pos1       = r_pos + PW'(1);
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_list_end = r_list_end;
        n_tag      = r_tag;
        n_len      = r_len;
        n_left     = r_left;
        n_field    = r_field;
        n_fmt0     = r_fmt0;
        n_fmt1     = r_fmt1;
        n_place    = r_place;
        n_ext      = r_ext;
        n_found    = r_found;
        skip_req   = 1'b0;
        next_req   = 1'b0;
        consumed   = '0;
        st_valid   = 1'b0;
        st_code    = rwhp_pkg::ST_OK;

        if (r_phase != PH_DONE) begin
            n_pos = pos1;
        end

        unique case (r_phase)
            PH_RIFF: begin
                n_field = {b, r_field[63:8]};
                if (r_pos < PW'(4)) begin
                    n_tag = {b, r_tag[31:8]};
                end else if (r_pos < PW'(8)) begin
                    n_len = {b, r_len[31:8]};
                end
                if (r_pos == PW'(rwhp_pkg::HDR_BYTES - 1)) begin
                    if (n_tag != rwhp_pkg::TAG_RIFF || n_field[63:32] != rwhp_pkg::TAG_WAVE) begin
                        st_valid = 1'b1;
                        st_code  = rwhp_pkg::ST_BAD_SIG;
                    end else begin
                        n_list_end = 33'(rwhp_pkg::CHUNK_HDR) + {1'b0, n_len};
                        next_req   = 1'b1;
                    end
                end
            end
            PH_CHUNK: begin
                if (r_left > LW'(4)) begin
                    n_tag = {b, r_tag[31:8]};
                end else begin
                    n_len = {b, r_len[31:8]};
                end
                n_left = r_left - LW'(1);
                if (r_left == LW'(1)) begin
                    if (n_tag == rwhp_pkg::TAG_FMT) begin
                        n_found[0] = 1'b1;
                        if (n_len < 32'(rwhp_pkg::FMT_BYTES)) begin
                            st_valid = 1'b1;
                            st_code  = rwhp_pkg::ST_FMT_SMALL;
                        end else begin
                            n_phase = PH_FMT;
                            n_left  = LW'(rwhp_pkg::FMT_BYTES);
                        end
                    end else begin
                        if (n_tag == rwhp_pkg::TAG_DATA) begin
                            n_found[1] = 1'b1;
                            n_place    = {n_len, pos1[31:0]};
                        end
                        skip_req = 1'b1;
                    end
                end
            end
            PH_FMT: begin
                n_field = {b, r_field[63:8]};
                n_left  = r_left - LW'(1);
                if (r_left == LW'(9)) begin
                    n_fmt0 = n_field;
                end
                if (r_left == LW'(1)) begin
                    n_fmt1 = n_field;
                    if (r_fmt0[15:0] == 16'd1) begin
                        n_ext    = '0;
                        consumed = LW'(rwhp_pkg::FMT_BYTES);
                        skip_req = 1'b1;
                    end else begin
                        n_phase = PH_EXTLEN;
                        n_left  = LW'(2);
                    end
                end
            end
            PH_EXTLEN: begin
                n_field = {b, r_field[63:8]};
                n_left  = r_left - LW'(1);
                if (r_left == LW'(1)) begin
                    n_ext = n_field[63:48];
                    if ({17'd0, n_ext} + LW'(rwhp_pkg::FMT_BYTES + 2) > {1'b0, n_len}) begin
                        st_valid = 1'b1;
                        st_code  = rwhp_pkg::ST_OVERRUN;
                    end else if (n_ext == 16'd0) begin
                        consumed = LW'(rwhp_pkg::FMT_BYTES + 2);
                        skip_req = 1'b1;
                    end else begin
                        n_phase = PH_EXT;
                        n_left  = {17'd0, n_ext};
                    end
                end
            end
            PH_EXT: begin
                n_left = r_left - LW'(1);
                if (r_left == LW'(1)) begin
                    consumed = {17'd0, r_ext} + LW'(rwhp_pkg::FMT_BYTES + 2);
                    skip_req = 1'b1;
                end
            end
            PH_SKIP: begin
                n_left = r_left - LW'(1);
                if (r_left == LW'(1)) begin
                    next_req = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // Skip the rest of the body, padded to even length
        len_inc = {1'b0, n_len} + LW'(1);
        padded  = {len_inc[LW-1:1], 1'b0};
        rem     = padded - consumed;
        if (skip_req) begin
            n_phase = PH_SKIP;
            n_left  = rem;
            if (rem == '0) begin
                next_req = 1'b1;
            end
        end

        // Chunk boundary: end of list or next chunk header
        if (next_req) begin
            if (pos1 >= {1'b0, r_list_end} && r_phase != PH_RIFF
                    || pos1 >= {1'b0, n_list_end} && r_phase == PH_RIFF) begin
                st_valid = 1'b1;
                st_code  = (n_found == 2'b11) ? rwhp_pkg::ST_OK : rwhp_pkg::ST_MISSING;
            end else begin
                n_phase = PH_CHUNK;
                n_left  = LW'(rwhp_pkg::CHUNK_HDR);
            end
        end

        res_valid = st_valid;
        res_code  = st_code;
        if (st_valid) begin
            n_phase = PH_DONE;
        end

        // Final byte: report if nothing was reported yet
        if (i_beat.end_of_file && !st_valid && r_phase != PH_DONE) begin
            res_valid = 1'b1;
            if (n_phase == PH_RIFF) begin
                res_code = rwhp_pkg::ST_SHORT;
            end else if (n_phase == PH_EXT) begin
                res_code = rwhp_pkg::ST_EXT_CUT;
            end else begin
                res_code = rwhp_pkg::ST_EARLY_END;
            end
        end
    end

    // Result fields come from the state as updated by this byte
    always_comb begin
        o_res_valid            = res_valid;
        o_res.status           = res_code;
        o_res.found_format     = n_found[0];
        o_res.found_samples    = n_found[1];
        o_res.format_tag       = n_fmt0[15:0];
        o_res.channel_count    = n_fmt0[31:16];
        o_res.sample_rate      = n_fmt0[63:32];
        o_res.byte_rate        = n_fmt1[31:0];
        o_res.block_align      = n_fmt1[47:32];
        o_res.sample_bits      = n_fmt1[63:48];
        o_res.extension_length = n_ext;
        o_res.samples_offset   = n_place[31:0];
        o_res.samples_length   = n_place[63:32];
    end

    // State update; end of file returns to the header phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_beat.end_of_file)) begin
            r_phase    <= PH_RIFF;
            r_pos      <= '0;
            r_list_end <= '0;
            r_tag      <= '0;
            r_len      <= '0;
            r_left     <= '0;
            r_field    <= '0;
            r_fmt0     <= '0;
            r_fmt1     <= '0;
            r_place    <= '0;
            r_ext      <= '0;
            r_found    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_list_end <= n_list_end;
            r_tag      <= n_tag;
            r_len      <= n_len;
            r_left     <= n_left;
            r_field    <= n_field;
            r_fmt0     <= n_fmt0;
            r_fmt1     <= n_fmt1;
            r_place    <= n_place;
            r_ext      <= n_ext;
            r_found    <= n_found;
        end
    end

endmodule

`default_nettype wire

### hdl/riff_wave_header_parser_unit.sv
// RIFF/WAVE header parser, one file byte per input beat.
// An accepted input beat is held in the input register, and its result beat in the result register.
// Throughput: one byte per cycle unless a held result beat waits on m_axis_tready.
// At most one result beat per file, on list end, error or final byte.
// Synchronous active-low reset returns the parser to the RIFF header phase.
// Depends on rwhp_pkg, rwhp_in_stage and rwhp_parser.
`default_nettype none

module riff_wave_header_parser_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [7:0]                           s_axis_tdata,  // file_byte
    input  wire                                  s_axis_tlast,  // end_of_file
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // status[2:0], found_format, found_samples, format_tag, channel_count,
    // sample_rate, byte_rate, block_align, sample_bits, extension_length,
    // samples_offset, samples_length, zero pad
    output logic [rwhp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    rwhp_pkg::t_beat   in_beat;
    rwhp_pkg::t_beat   held_beat;
    rwhp_pkg::t_result res;
    rwhp_pkg::t_result r_out;
    logic              held_valid;
    logic              step;
    logic              res_valid;
    logic              r_out_valid;

    assign in_beat.file_byte   = s_axis_tdata;
    assign in_beat.end_of_file = s_axis_tlast;

    // The held beat advances when the result slot is free or draining
    assign step = held_valid && (!r_out_valid || m_axis_tready);

    rwhp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_beat  (in_beat),
        .i_take  (step),
        .o_valid (held_valid),
        .o_beat  (held_beat)
    );

    rwhp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_beat      (held_beat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0,
                            r_out.samples_length,
                            r_out.samples_offset,
                            r_out.extension_length,
                            r_out.sample_bits,
                            r_out.block_align,
                            r_out.byte_rate,
                            r_out.sample_rate,
                            r_out.channel_count,
                            r_out.format_tag,
                            r_out.found_samples,
                            r_out.found_format,
                            r_out.status};

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for riff_wave_header_parser_unit: streams whole WAV files byte by byte
// and checks every summary beat against an in-bench model of the header walk.
// Depends on rwhp_pkg and the parser RTL under hdl/.
`timescale 1ns / 100ps

module tb;
    import rwhp_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int RAND_BYTES      = 1200;
    localparam int RAND_FILES_MIN  = 20;
    localparam int NO_RESULT       = -1;
    localparam int NUM_PROBES      = 22;
    localparam logic [31:0] TAG_LIST = 32'h5453_494c;
    localparam logic [31:0] TAG_RIFX = 32'h5846_4952;

    // Header walk phases of the model
    typedef enum logic [2:0] {
        WALK_HEADER, WALK_CHUNK_HDR, WALK_FMT, WALK_EXT_LEN, WALK_EXT, WALK_SKIP, WALK_DONE
    } walk_phase_e;

    // Directed file shapes
    typedef enum {
        PR_PCM, PR_ONE_BYTE, PR_ELEVEN, PR_BAD_RIFF, PR_BAD_WAVE, PR_EMPTY_LIST,
        PR_LIST_AT_12, PR_NO_SAMPLES, PR_NO_FORMAT, PR_HDR_ONLY, PR_CHUNK_CUT,
        PR_FMT_CUT, PR_FMT_SMALL, PR_EXT_OK, PR_EXT_ZERO, PR_EXTLEN_CUT, PR_EXT_CUT,
        PR_OVERRUN, PR_ODD_SKIP, PR_ALL_ONES, PR_HUGE_DATA, PR_LIST_PASSED
    } probe_e;

    typedef struct {
        probe_e     kind;
        logic [2:0] status;
    } probe_row_t;

    // Per-file note: a directed file carries its status typed in
    typedef struct packed {
        bit         typed;
        logic [2:0] status;
    } status_note_t;

    probe_row_t probes [NUM_PROBES] = '{
        '{PR_PCM,        ST_OK},
        '{PR_ONE_BYTE,   ST_SHORT},
        '{PR_ELEVEN,     ST_SHORT},
        '{PR_BAD_RIFF,   ST_BAD_SIG},
        '{PR_BAD_WAVE,   ST_BAD_SIG},
        '{PR_EMPTY_LIST, ST_MISSING},
        '{PR_LIST_AT_12, ST_MISSING},
        '{PR_NO_SAMPLES, ST_MISSING},
        '{PR_NO_FORMAT,  ST_MISSING},
        '{PR_HDR_ONLY,   ST_EARLY_END},
        '{PR_CHUNK_CUT,  ST_EARLY_END},
        '{PR_FMT_CUT,    ST_EARLY_END},
        '{PR_FMT_SMALL,  ST_FMT_SMALL},
        '{PR_EXT_OK,     ST_OK},
        '{PR_EXT_ZERO,   ST_OK},
        '{PR_EXTLEN_CUT, ST_EARLY_END},
        '{PR_EXT_CUT,    ST_EXT_CUT},
        '{PR_OVERRUN,    ST_OVERRUN},
        '{PR_ODD_SKIP,   ST_OK},
        '{PR_ALL_ONES,   ST_EXT_CUT},
        '{PR_HUGE_DATA,  ST_EARLY_END},
        '{PR_LIST_PASSED, ST_OK}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'd0;   // file_byte
    logic                   s_axis_tlast = 1'b0;   // end_of_file
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // status .. samples_length, zero pad

    riff_wave_header_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Model state of the header walk
    walk_phase_e walk;
    logic [63:0] pos;
    logic [63:0] list_end_pos;
    logic [63:0] left;
    logic [31:0] tag_sr;
    logic [31:0] len_sr;
    logic [31:0] ext_len;
    logic [63:0] field_sr;
    logic [63:0] fmt_lo;
    logic [63:0] fmt_hi;
    logic [63:0] place;
    logic [1:0]  seen;
    logic        done_flag;

    t_result      pending_summaries[$];
    status_note_t status_notes[$];
    logic [7:0]   file_q[$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 27;
    int           recv_idle_pct = 62;

    function automatic void parser_clear();
        walk = WALK_HEADER;
        pos = '0;
        list_end_pos = '0;
        left = '0;
        tag_sr = '0;
        len_sr = '0;
        ext_len = '0;
        field_sr = '0;
        fmt_lo = '0;
        fmt_hi = '0;
        place = '0;
        seen = '0;
        done_flag = 1'b0;
    endfunction

    // At a chunk boundary: either the list is over or a new header starts
    function automatic int chunk_boundary();
        if (pos >= list_end_pos)
            return (seen == 2'b11) ? int'(ST_OK) : int'(ST_MISSING);
        walk = WALK_CHUNK_HDR;
        left = 64'd8;
        tag_sr = '0;
        len_sr = '0;
        return NO_RESULT;
    endfunction

    // Skip what remains of the body, padded to even length
    function automatic int skip_body(logic [63:0] used);
        logic [63:0] padded;
        padded = ({32'd0, len_sr} + 64'd1) & ~64'd1;
        left = padded - used;
        walk = WALK_SKIP;
        if (left == 0)
            return chunk_boundary();
        return NO_RESULT;
    endfunction

    function automatic int header_end();
        if (tag_sr == TAG_FMT) begin
            seen[0] = 1'b1;
            if (len_sr < FMT_BYTES)
                return int'(ST_FMT_SMALL);
            walk = WALK_FMT;
            left = 64'(FMT_BYTES);
            field_sr = '0;
            return NO_RESULT;
        end
        if (tag_sr == TAG_DATA) begin
            seen[1] = 1'b1;
            place = {len_sr, pos[31:0]};
        end
        return skip_body(64'd0);
    endfunction

    function automatic int take_byte(logic [7:0] b);
        logic [63:0] idx;
        pos = pos + 64'd1;
        case (walk)
            WALK_HEADER: begin
                idx = pos - 64'd1;
                if (idx < 4)
                    tag_sr = {b, tag_sr[31:8]};
                else if (idx < 8)
                    len_sr = {b, len_sr[31:8]};
                else
                    field_sr = {32'd0, b, field_sr[31:8]};
                if (idx == HDR_BYTES - 1) begin
                    if (tag_sr != TAG_RIFF || field_sr != {32'd0, TAG_WAVE})
                        return int'(ST_BAD_SIG);
                    list_end_pos = 64'd8 + {32'd0, len_sr};
                    return chunk_boundary();
                end
            end
            WALK_CHUNK_HDR: begin
                idx = 64'd8 - left;
                if (idx < 4)
                    tag_sr = {b, tag_sr[31:8]};
                else
                    len_sr = {b, len_sr[31:8]};
                left = left - 64'd1;
                if (left == 0)
                    return header_end();
            end
            WALK_FMT: begin
                field_sr = {b, field_sr[63:8]};
                left = left - 64'd1;
                if (left == 8)
                    fmt_lo = field_sr;
                if (left == 0) begin
                    fmt_hi = field_sr;
                    if (fmt_lo[15:0] == 16'd1) begin
                        ext_len = '0;
                        return skip_body(64'(FMT_BYTES));
                    end
                    walk = WALK_EXT_LEN;
                    left = 64'd2;
                    field_sr = '0;
                end
            end
            WALK_EXT_LEN: begin
                field_sr = {48'd0, b, field_sr[15:8]};
                left = left - 64'd1;
                if (left == 0) begin
                    ext_len = {16'd0, field_sr[15:0]};
                    if (64'd18 + {32'd0, ext_len} > {32'd0, len_sr})
                        return int'(ST_OVERRUN);
                    if (ext_len == 0)
                        return skip_body(64'd18);
                    walk = WALK_EXT;
                    left = {32'd0, ext_len};
                end
            end
            WALK_EXT: begin
                left = left - 64'd1;
                if (left == 0)
                    return skip_body(64'd18 + {32'd0, ext_len});
            end
            WALK_SKIP: begin
                left = left - 64'd1;
                if (left == 0)
                    return chunk_boundary();
            end
            default: ;
        endcase
        return NO_RESULT;
    endfunction

    function automatic t_result summarize(int st);
        t_result s;
        s.status           = st[2:0];
        s.found_format     = seen[0];
        s.found_samples    = seen[1];
        s.format_tag       = fmt_lo[15:0];
        s.channel_count    = fmt_lo[31:16];
        s.sample_rate      = fmt_lo[63:32];
        s.byte_rate        = fmt_hi[31:0];
        s.block_align      = fmt_hi[47:32];
        s.sample_bits      = fmt_hi[63:48];
        s.extension_length = ext_len[15:0];
        s.samples_offset   = place[31:0];
        s.samples_length   = place[63:32];
        done_flag = 1'b1;
        walk = WALK_DONE;
        return s;
    endfunction

    // One file byte through the model; at most one summary comes out
    function automatic void parse_wav_byte(input logic [7:0] b, input logic eof,
                                           output bit made, output t_result summary);
        int st;
        made = 1'b0;
        summary = '0;
        st = NO_RESULT;
        if (!done_flag && walk != WALK_DONE)
            st = take_byte(b);
        if (st >= 0) begin
            summary = summarize(st);
            made = 1'b1;
        end
        if (eof) begin
            if (!done_flag) begin
                if (walk == WALK_HEADER)
                    st = int'(ST_SHORT);
                else if (walk == WALK_EXT)
                    st = int'(ST_EXT_CUT);
                else
                    st = int'(ST_EARLY_END);
                summary = summarize(st);
                made = 1'b1;
            end
            parser_clear();
        end
    endfunction

    // File builders
    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_noise(int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(8'($urandom));
    endfunction

    function automatic void put_wav_head(logic [31:0] riff_tag, logic [31:0] form_tag);
        put_le(riff_tag, 4);
        put_le(32'd0, 4);
        put_le(form_tag, 4);
    endfunction

    function automatic void set_riff_len(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_q[4+i] = v[8*i +: 8];
    endfunction

    function automatic void put_chunk_head(logic [31:0] tag, logic [31:0] clen);
        put_le(tag, 4);
        put_le(clen, 4);
    endfunction

    function automatic void put_fmt(logic [31:0] clen, logic [15:0] ftag, logic [15:0] chans,
                                    logic [31:0] rate, logic [31:0] brate,
                                    logic [15:0] align, logic [15:0] bits);
        put_chunk_head(TAG_FMT, clen);
        put_le({16'd0, ftag}, 2);
        put_le({16'd0, chans}, 2);
        put_le(rate, 4);
        put_le(brate, 4);
        put_le({16'd0, align}, 2);
        put_le({16'd0, bits}, 2);
    endfunction

    // Fill the rest of a small body with noise, up to its even length
    function automatic void put_pad(int written, logic [31:0] clen);
        longint target;
        target = (longint'(clen) + 1) & ~longint'(1);
        for (longint j = written; j < target; j++)
            file_q.push_back(8'($urandom));
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] seen_v, logic [31:0] want_v);
        if (seen_v !== want_v)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, seen_v, want_v));
    endtask

    // Send the bytes in file_q, the last one flagged as end of file
    task automatic send_file(bit typed, logic [2:0] st);
        status_note_t note;
        note.typed = typed;
        note.status = st;
        status_notes.push_back(note);
        for (int i = 0; i < file_q.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= file_q[i];
            s_axis_tlast <= (i == file_q.size() - 1);
            @(posedge i_clk);
            while (!s_axis_tready)
                @(posedge i_clk);
        end
    endtask

    // Result side backpressure
    initial begin
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Beat monitor: predict on input beats, compare on result beats
    always @(posedge i_clk) begin : beat_monitor
        t_result      summary;
        t_result      due;
        status_note_t note;
        bit           made;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_wav_byte(s_axis_tdata, s_axis_tlast, made, summary);
                if (made) begin
                    note = status_notes.pop_front();
                    if (note.typed)
                        summary.status = note.status;
                    pending_summaries.push_back(summary);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_summaries.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    due = pending_summaries.pop_front();
                    check_field("status", m_axis_tdata[2:0], due.status);
                    check_field("found_format", m_axis_tdata[3], due.found_format);
                    check_field("found_samples", m_axis_tdata[4], due.found_samples);
                    check_field("format_tag", m_axis_tdata[5 +: 16], due.format_tag);
                    check_field("channel_count", m_axis_tdata[21 +: 16], due.channel_count);
                    check_field("sample_rate", m_axis_tdata[37 +: 32], due.sample_rate);
                    check_field("byte_rate", m_axis_tdata[69 +: 32], due.byte_rate);
                    check_field("block_align", m_axis_tdata[101 +: 16], due.block_align);
                    check_field("sample_bits", m_axis_tdata[117 +: 16], due.sample_bits);
                    check_field("extension_length", m_axis_tdata[133 +: 16],
                                due.extension_length);
                    check_field("samples_offset", m_axis_tdata[149 +: 32], due.samples_offset);
                    check_field("samples_length", m_axis_tdata[181 +: 32], due.samples_length);
                    check_field("pad", m_axis_tdata[215:213], 32'd0);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // Watchdog on cycles with no beat moving
    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("riff_wave_header_parser_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        int          row;
        int          slot;
        int          pick;
        int          n;
        int          rand_bytes;
        int          rand_files;
        logic [31:0] clen;
        logic [15:0] ftag;
        logic [15:0] xlen;
        rand_bytes = 0;
        rand_files = 0;
        parser_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed files, one per table row
        for (row = 0; row < NUM_PROBES; row++) begin
            file_q.delete();
            case (probes[row].kind)
                PR_PCM: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    put_fmt(32'd16, 16'd1, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
                    put_chunk_head(TAG_DATA, 32'd4);
                    put_noise(4);
                    set_riff_len(32'(file_q.size() - 8));
                end
                PR_ONE_BYTE: put_le(32'hFF, 1);
                PR_ELEVEN: begin
                    put_le(TAG_RIFF, 4);
                    put_le(32'd36, 4);
                    put_noise(3);
                end
                PR_BAD_RIFF: begin
                    put_wav_head(TAG_RIFX, TAG_WAVE);
                    set_riff_len(32'd40);
                    put_noise(6);
                end
                PR_BAD_WAVE: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE ^ 32'h0100_0000);
                    set_riff_len(32'd40);
                    put_noise(3);
                end
                PR_EMPTY_LIST: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'd3);
                    put_noise(5);
                end
                PR_LIST_AT_12: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'd4);
                end
                PR_NO_SAMPLES: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    put_fmt(32'd16, 16'd1, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8);
                    set_riff_len(32'(file_q.size() - 8));
                end
                PR_NO_FORMAT: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    put_chunk_head(TAG_DATA, 32'd2);
                    put_noise(2);
                    set_riff_len(32'(file_q.size() - 8));
                end
                PR_HDR_ONLY: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'd100);
                end
                PR_CHUNK_CUT: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'd100);
                    put_le(TAG_FMT, 4);
                    put_noise(1);
                end
                PR_FMT_CUT: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'd100);
                    put_chunk_head(TAG_FMT, 32'd16);
                    put_noise(7);
                end
                PR_FMT_SMALL: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'd100);
                    put_chunk_head(TAG_FMT, 32'd14);
                    put_noise(14);
                end
                PR_EXT_OK: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    put_fmt(32'd40, 16'hFFFE, 16'd6, 32'd48000, 32'd864000, 16'd18, 16'd24);
                    put_le(32'd22, 2);
                    put_noise(22);
                    put_chunk_head(TAG_DATA, 32'd3);
                    put_noise(4);
                    set_riff_len(32'(file_q.size() - 8));
                end
                PR_EXT_ZERO: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    put_fmt(32'd18, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 16'd0);
                    put_le(32'd0, 2);
                    put_chunk_head(TAG_DATA, 32'd0);
                    set_riff_len(32'(file_q.size() - 8));
                end
                PR_EXTLEN_CUT: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'd100);
                    put_fmt(32'd18, 16'd3, 16'd1, 32'd8000, 32'd32000, 16'd4, 16'd32);
                    put_noise(1);
                end
                PR_EXT_CUT: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'd200);
                    put_fmt(32'd40, 16'hFFFE, 16'd2, 32'd96000, 32'd384000, 16'd4, 16'd16);
                    put_le(32'd22, 2);
                    put_noise(5);
                end
                PR_OVERRUN: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'd100);
                    put_fmt(32'd20, 16'd2, 16'd1, 32'd22050, 32'd11025, 16'd1, 16'd4);
                    put_le(32'd3, 2);
                    put_noise(4);
                end
                PR_ODD_SKIP: begin
                    // odd bodies on a foreign chunk and on the format chunk
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    put_chunk_head(TAG_LIST, 32'd3);
                    put_noise(4);
                    put_fmt(32'd17, 16'd1, 16'd1, 32'd11025, 32'd22050, 16'd2, 16'd16);
                    put_noise(2);
                    put_chunk_head(TAG_DATA, 32'd1);
                    put_noise(2);
                    set_riff_len(32'(file_q.size() - 8));
                end
                PR_ALL_ONES: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'hFFFF_FFFF);
                    put_fmt(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            16'hFFFF, 16'hFFFF);
                    put_le(32'hFFFF, 2);
                    put_le(32'hFF_FFFF, 3);
                end
                PR_HUGE_DATA: begin
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    set_riff_len(32'hFFFF_FFFF);
                    put_fmt(32'd16, 16'd1, 16'($urandom), $urandom, $urandom,
                            16'($urandom), 16'($urandom));
                    put_chunk_head(TAG_DATA, 32'hFFFF_FFFF);
                    put_noise(4);
                end
                PR_LIST_PASSED: begin
                    // list end falls inside the data chunk header
                    put_wav_head(TAG_RIFF, TAG_WAVE);
                    put_fmt(32'd16, 16'd1, 16'd2, 32'd32000, 32'd128000, 16'd4, 16'd16);
                    put_chunk_head(TAG_DATA, 32'd8);
                    put_noise(8);
                    set_riff_len(32'd30);
                    put_noise(3);
                end
                default: ;
            endcase
            send_file(1'b1, probes[row].status);
        end

        // Random files: mostly well formed with random content
        while (rand_bytes < RAND_BYTES || rand_files < RAND_FILES_MIN) begin
            if (rand_bytes < RAND_BYTES / 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 62;
            end else if (rand_bytes < 2 * RAND_BYTES / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            file_q.delete();
            pick = $urandom_range(99);
            if (pick < 5) begin
                put_noise($urandom_range(30, 1));
            end else if (pick < 10) begin
                put_wav_head(TAG_RIFF, TAG_WAVE);
                set_riff_len($urandom);
                put_noise($urandom_range(40));
            end else begin
                put_wav_head(TAG_RIFF, TAG_WAVE);
                for (slot = 0; slot < 5; slot++) begin
                    case (slot)
                        1: if ($urandom_range(9) != 0) begin
                            ftag = $urandom_range(1) ? 16'd1 : 16'($urandom);
                            if (ftag == 16'd1) begin
                                clen = 32'd16 + $urandom_range(3);
                                put_fmt(clen, ftag, 16'($urandom), $urandom, $urandom,
                                        16'($urandom), 16'($urandom));
                                put_pad(16, clen);
                            end else begin
                                xlen = 16'($urandom_range(6));
                                clen = 32'd18 + xlen + $urandom_range(3);
                                n = $urandom_range(19);
                                if (n == 0)
                                    clen = $urandom_range(15);
                                else if (n == 1)
                                    clen = 32'd17 + xlen;
                                else if (n == 2)
                                    xlen = 16'($urandom);
                                put_fmt(clen, ftag, 16'($urandom), $urandom, $urandom,
                                        16'($urandom), 16'($urandom));
                                put_le({16'd0, xlen}, 2);
                                if (xlen <= 6)
                                    put_noise(int'(xlen));
                                put_pad(18 + xlen, clen);
                            end
                        end
                        3: if ($urandom_range(9) != 0) begin
                            if ($urandom_range(19) == 0) begin
                                put_chunk_head(TAG_DATA, $urandom);
                                put_noise($urandom_range(6));
                            end else begin
                                clen = $urandom_range(9);
                                put_chunk_head(TAG_DATA, clen);
                                put_pad(0, clen);
                            end
                        end
                        default: if ($urandom_range(9) < 3) begin
                            clen = $urandom_range(7);
                            put_chunk_head($urandom, clen);
                            put_pad(0, clen);
                        end
                    endcase
                end
                n = $urandom_range(19);
                if (n < 16)
                    set_riff_len(32'(file_q.size() - 8));
                else if (n < 19)
                    set_riff_len(32'(file_q.size() - 8 + $urandom_range(12) - 6));
                else
                    set_riff_len($urandom);
                // truncated file, trailing junk, a corrupted byte
                if ($urandom_range(6) == 0) begin
                    n = $urandom_range(file_q.size() - 1, 1);
                    while (file_q.size() > n)
                        void'(file_q.pop_back());
                end
                if ($urandom_range(9) == 0)
                    put_noise($urandom_range(8, 1));
                if ($urandom_range(19) == 0)
                    file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
            end
            send_file(1'b0, ST_OK);
            rand_bytes += file_q.size();
            rand_files++;
        end

        // Drain
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("riff_wave_header_parser_unit: match");
        else
            $display("riff_wave_header_parser_unit: mismatch");
        $finish;
    end

endmodule
